// File: rtl/assert_macros.svh
// assertion macro used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while reset is low
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: rtl/i2cbm_pkg.sv
// types, codes and sequence tables of the i2c bit-level master
// no dependencies
package i2cbm_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

    localparam logic [7:0] HOLD_TICKS_RST  = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    // action codes on the input stream
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;
    localparam logic [2:0] ACT_ACK   = 3'd5;

    typedef enum logic [7:0] {
        CMD_IDLE    = 8'b0000_0001,
        CMD_START   = 8'b0000_0010,
        CMD_STOP    = 8'b0000_0100,
        CMD_WRITE   = 8'b0000_1000,
        CMD_READ    = 8'b0001_0000,
        CMD_ACKHEAD = 8'b0010_0000,
        CMD_ACKPOLL = 8'b0100_0000,
        CMD_ACKTAIL = 8'b1000_0000
    } cmd_t;

    typedef enum logic [2:0] {
        OP_SCL0 = 3'd0,
        OP_SCL1 = 3'd1,
        OP_SDA0 = 3'd2,
        OP_SDA1 = 3'd3,
        OP_HOLD = 3'd4,
        OP_SAMP = 3'd5
    } op_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] phase;
        logic [3:0] bitc;
        logic [7:0] shift;
        logic [7:0] hold;
        logic [7:0] poll;
        logic       scl;
        logic       sda;
        logic       fail;
        logic [7:0] rx;
    } state_t;

    typedef struct packed {
        logic [7:0] hold_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    function automatic cmd_t act_to_cmd(input logic [2:0] action);
        cmd_t c;
        unique case (action)
            ACT_START: c = CMD_START;
            ACT_STOP:  c = CMD_STOP;
            ACT_WRITE: c = CMD_WRITE;
            ACT_READ:  c = CMD_READ;
            ACT_ACK:   c = CMD_ACKHEAD;
            default:   c = CMD_IDLE;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] seq_len(input cmd_t cmd, input logic msb);
        logic [3:0] n;
        unique case (cmd)
            CMD_START:   n = 4'd8;
            CMD_STOP:    n = 4'd6;
            CMD_WRITE:   n = msb ? 4'd5 : 4'd4;
            CMD_READ:    n = 4'd5;
            CMD_ACKHEAD: n = 4'd4;
            default:     n = 4'd2;
        endcase
        return n;
    endfunction

    function automatic op_t seq_op(input cmd_t cmd, input logic msb, input logic [3:0] ph);
        op_t o;
        o = OP_SCL0;
        unique case (cmd)
            CMD_START: begin
                case (ph)
                    4'd1, 4'd4, 4'd6: o = OP_HOLD;
                    4'd2:             o = OP_SDA1;
                    4'd3:             o = OP_SCL1;
                    4'd5:             o = OP_SDA0;
                    default:          o = OP_SCL0;
                endcase
            end
            CMD_STOP: begin
                case (ph)
                    4'd0:       o = OP_SDA0;
                    4'd1:       o = OP_SCL1;
                    4'd2, 4'd4: o = OP_HOLD;
                    4'd3:       o = OP_SDA1;
                    default:    o = OP_SCL0;
                endcase
            end
            CMD_WRITE: begin
                if (msb)
                begin
                    case (ph)
                        4'd0:       o = OP_SDA1;
                        4'd1, 4'd3: o = OP_HOLD;
                        4'd2:       o = OP_SCL1;
                        default:    o = OP_SCL0;
                    endcase
                end
                else
                begin
                    case (ph)
                        4'd0:    o = OP_SDA0;
                        4'd1:    o = OP_SCL1;
                        4'd2:    o = OP_HOLD;
                        default: o = OP_SCL0;
                    endcase
                end
            end
            CMD_READ: begin
                case (ph)
                    4'd0:    o = OP_SDA1;
                    4'd1:    o = OP_SCL1;
                    4'd2:    o = OP_HOLD;
                    4'd3:    o = OP_SAMP;
                    default: o = OP_SCL0;
                endcase
            end
            CMD_ACKHEAD: begin
                case (ph)
                    4'd0, 4'd2: o = OP_HOLD;
                    4'd1:       o = OP_SCL1;
                    default:    o = OP_SAMP;
                endcase
            end
            default: begin
                o = (ph == 4'd0) ? OP_HOLD : OP_SCL0;
            end
        endcase
        return o;
    endfunction

endpackage

// File: rtl/i2cbm_step.sv
// next-state logic of the line sequencer for one tick
// depends on i2cbm_pkg
module i2cbm_step (
    input  i2cbm_pkg::state_t cur,
    input  i2cbm_pkg::cfg_t   cfg,
    input  logic [2:0]        action,
    input  logic [7:0]        tx_byte,
    input  logic              sda_in,
    output i2cbm_pkg::state_t nxt,
    output logic              done
);
    import i2cbm_pkg::*;

    state_t     st;
    cmd_t       new_cmd;
    op_t        op;
    logic [3:0] len_v;
    logic [7:0] hold_load;
    logic [7:0] poll_load;
    logic       stall;

    assign new_cmd   = act_to_cmd(action);
    assign hold_load = (cfg.hold_ticks == 8'd0) ? 8'd1 : cfg.hold_ticks;
    assign poll_load = (cfg.ack_timeout == 8'd0) ? 8'd1 : cfg.ack_timeout;

    always_comb
    begin
        st    = cur;
        done  = 1'b0;
        stall = 1'b0;
        op    = OP_SCL0;
        len_v = 4'd0;

        // commands are only taken while idle
        if (st.cmd == CMD_IDLE && new_cmd != CMD_IDLE)
        begin
            st.cmd   = new_cmd;
            st.phase = 4'd0;
            st.hold  = 8'd0;
            st.bitc  = 4'd0;
            if (new_cmd == CMD_WRITE)
                st.shift = tx_byte;
            else if (new_cmd == CMD_READ)
                st.shift = 8'd0;
        end

        if (st.cmd != CMD_IDLE)
        begin
            if (st.cmd == CMD_ACKPOLL)
            begin
                st.poll = st.poll - 8'd1;
                if (st.poll == 8'd0)
                begin
                    // poll budget spent: flag failure and release the bus
                    st.fail  = 1'b1;
                    st.cmd   = CMD_STOP;
                    st.phase = 4'd0;
                    st.hold  = 8'd0;
                end
                else if (!sda_in)
                begin
                    st.cmd   = CMD_ACKTAIL;
                    st.phase = 4'd0;
                    st.hold  = 8'd0;
                end
            end
            else
            begin
                len_v = seq_len(st.cmd, st.shift[7]);
                if (st.phase >= len_v)
                    st.phase = 4'd0;
                op = seq_op(st.cmd, st.shift[7], st.phase);

                case (op)
                    OP_SCL0: st.scl = 1'b0;
                    OP_SCL1: st.scl = 1'b1;
                    OP_SDA0: st.sda = 1'b0;
                    OP_SDA1: st.sda = 1'b1;
                    OP_HOLD: begin
                        if (st.hold == 8'd0)
                            st.hold = hold_load;
                        st.hold = st.hold - 8'd1;
                        if (st.hold != 8'd0)
                            stall = 1'b1;
                    end
                    default: begin
                        if (st.cmd == CMD_READ)
                            st.shift = {st.shift[6:0], sda_in};
                    end
                endcase

                if (!stall)
                begin
                    st.phase = st.phase + 4'd1;
                    if (st.phase >= len_v)
                    begin
                        st.phase = 4'd0;
                        unique case (st.cmd)
                            CMD_WRITE: begin
                                st.shift = {st.shift[6:0], 1'b0};
                                st.bitc  = st.bitc + 4'd1;
                                done     = (st.bitc >= BITS_PER_BYTE);
                            end
                            CMD_READ: begin
                                st.bitc = st.bitc + 4'd1;
                                if (st.bitc >= BITS_PER_BYTE)
                                begin
                                    st.rx = st.shift;
                                    done  = 1'b1;
                                end
                            end
                            CMD_ACKHEAD: begin
                                st.phase = 4'd0;
                                st.hold  = 8'd0;
                                if (!sda_in)
                                    st.cmd = CMD_ACKTAIL;
                                else
                                begin
                                    st.poll = poll_load;
                                    st.cmd  = CMD_ACKPOLL;
                                end
                            end
                            CMD_ACKTAIL: begin
                                st.fail = 1'b0;
                                done    = 1'b1;
                            end
                            default: done = 1'b1;
                        endcase
                    end
                end
            end

            if (done)
            begin
                st.cmd   = CMD_IDLE;
                st.phase = 4'd0;
                st.hold  = 8'd0;
            end
        end
    end

    assign nxt = st;

endmodule

// File: rtl/i2c_bit_level_master_core.sv
// top level of the i2c bit-level master: config registers, state, output skid buffer
// depends on i2cbm_pkg and i2cbm_step
// Each input transfer is one bus tick and yields exactly one output transfer carrying
// the SCL/SDA drive levels and status after that tick. One transfer is taken every clock
// cycle while the skid entry is empty; the result goes to the output register, or to the
// skid entry while the output is stalled. The rate is set by the combinational next-state
// logic feeding the state registers; the two-entry output buffer takes one more transfer
// while stalled. Line timing is counted in ticks: a hold lasts max(hold_ticks,1) transfers.
module i2c_bit_level_master_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [i2cbm_pkg::IN_W-1:0]          s_tdata,   // action[2:0], tx_byte[10:3], sda_in[11]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [i2cbm_pkg::OUT_W-1:0]         m_tdata,   // scl_out[0], sda_out[1], busy_res[2],
                                                           // done_res[3], rx_byte[11:4], ack_failed[12]
    input  logic                                cfg_we,
    input  logic [i2cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cbm_pkg::CFG_W-1:0]         cfg_data
);
    import i2cbm_pkg::*;

    cfg_t             cfg_reg;
    state_t           state_reg;
    state_t           state_next;
    logic             step_done;
    logic [OUT_W-1:0] res;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_fire;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;

    i2cbm_step u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .action  (s_tdata[2:0]),
        .tx_byte (s_tdata[10:3]),
        .sda_in  (s_tdata[11]),
        .nxt     (state_next),
        .done    (step_done)
    );

    assign res = {3'd0, state_next.fail, state_next.rx, step_done,
                  (state_next.cmd != CMD_IDLE), state_next.sda, state_next.scl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks  <= HOLD_TICKS_RST;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HOLD_TICKS:  cfg_reg.hold_ticks  <= cfg_data;
                REG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // idle with both lines released
            state_reg <= '{cmd: CMD_IDLE, phase: 4'd0, bitc: 4'd0, shift: 8'd0, hold: 8'd0,
                           poll: 8'd0, scl: 1'b1, sda: 1'b1, fail: 1'b0, rx: 8'd0};
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire)
                out_data_reg <= res;
        end
        else if (in_fire)
        begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/i2cbm_checker.sv
// port-level checks of the i2c bit-level master, bound to the top level
// depends on assert_macros.svh and i2cbm_pkg
`include "assert_macros.svh"

module i2cbm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [i2cbm_pkg::OUT_W-1:0] m_tdata
);
    // a completing tick never reports busy
    `ASSERT_CLKD(a_done_not_busy, clk, rst_n, (m_tvalid && m_tdata[3]) |-> !m_tdata[2], "done with busy set")
    // input only closes while a result is waiting
    `ASSERT_CLKD(a_tready_low_has_out, clk, rst_n, !s_tready |-> m_tvalid, "input stalled with empty output")
    // every input transfer is followed by a valid output on the next cycle
    `ASSERT_CLKD(a_in_gives_out, clk, rst_n, (s_tvalid && s_tready) |=> m_tvalid, "transfer lost")
    // stalled result holds
    `ASSERT_CLKD(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind i2c_bit_level_master_core i2cbm_checker u_i2cbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
